[src/pclr_pkg.sv]
// ----------------------------------------------------------------------------
// pclr_pkg
// Shared constants, field types and controller/datapath interface structs for
// the positional symbol list with longest-run report.
// ----------------------------------------------------------------------------
package pclr_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int SYM_W    = 8;
   localparam int OPC_W    = 2;
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 6;
   localparam int RUN_W    = 6;
   localparam int CMP_W    = ((LEN_W > INDEX_W) ? LEN_W : INDEX_W) + 1;

   localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPC_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OPC_W-1:0] OP_REPORT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_FRONT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BACK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INDEX = 2'd2;

   typedef logic [SYM_W-1:0]   sym_type;
   typedef logic [OPC_W-1:0]   opc_type;
   typedef logic [MODE_W-1:0]  mode_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [RUN_W-1:0]   run_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_ins;
      logic load_del;
      logic load_rep;
      logic step_ins;
      logic put_ins;
      logic step_del;
      logic fin_del;
      logic scan_step;
      logic scan_restart;
      logic emit_step;
      logic emit_count;
   } pclr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ins_ok;
      logic del_ok;
      logic ins_done;
      logic del_done;
      logic scan_done;
      logic out_free;
   } pclr_sts_type;

endpackage

[src/pclr_ctrl.sv]
// ----------------------------------------------------------------------------
// pclr_ctrl
// Controller state machine: accepts commands and sequences the shift, scan
// and emit passes of the datapath.
// ----------------------------------------------------------------------------
module pclr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pclr_pkg::opc_type     req_opcode,
   input  pclr_pkg::pclr_sts_type sts,
   output pclr_pkg::pclr_cmd_type cmd
);
   import pclr_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INS   = 3'd1;
   localparam logic [2:0] ST_DEL   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_COUNT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_INSERT: begin
                     if (sts.ins_ok) begin
                        cmd.load_ins = 1'b1;
                        state_in     = ST_INS;
                     end
                  end
                  OP_DELETE: begin
                     if (sts.del_ok) begin
                        cmd.load_del = 1'b1;
                        state_in     = ST_DEL;
                     end
                  end
                  OP_REPORT: begin
                     cmd.load_rep = 1'b1;
                     state_in     = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_INS: begin
            if (sts.ins_done) begin
               cmd.put_ins = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.step_ins = 1'b1;
            end
         end
         ST_DEL: begin
            if (sts.del_done) begin
               cmd.fin_del = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.step_del = 1'b1;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               cmd.scan_restart = 1'b1;
               state_in         = ST_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (sts.scan_done) begin
               state_in = ST_COUNT;
            end else if (sts.out_free) begin
               cmd.emit_step = 1'b1;
            end
         end
         ST_COUNT: begin
            if (sts.out_free) begin
               cmd.emit_count = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/pclr_dp.sv]
// ----------------------------------------------------------------------------
// pclr_dp
// Datapath: symbol storage, list length, walk pointer, run counters and the
// result output register.
// ----------------------------------------------------------------------------
module pclr_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pclr_pkg::mode_type     req_mode,
   input  pclr_pkg::index_type    req_index,
   input  pclr_pkg::sym_type      req_symbol,
   input  pclr_pkg::pclr_cmd_type cmd,
   output pclr_pkg::pclr_sts_type sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_count,
   output pclr_pkg::sym_type      rsp_symbol,
   output pclr_pkg::run_type      rsp_run,
   output logic                   rsp_last
);
   import pclr_pkg::*;

   sym_type            store_ff [CAPACITY];
   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   ptr_ff;
   logic [ADDR_W-1:0]  slot_ff;
   sym_type            sym_ff;
   sym_type            prev_ff;
   logic [LEN_W-1:0]   run_ff;
   logic [LEN_W-1:0]   best_ff;
   logic               out_valid_ff;
   logic               out_count_ff;
   sym_type            out_sym_ff;
   run_type            out_run_ff;

   logic [LEN_W-1:0]   rd_ptr;
   sym_type            rd_data;
   logic [LEN_W-1:0]   run_next;
   logic [CMP_W-1:0]   len_c;
   logic [CMP_W-1:0]   idx_c;
   logic [ADDR_W-1:0]  ins_slot;
   logic [ADDR_W-1:0]  del_slot;
   logic               ins_pos_ok;
   logic               del_pos_ok;
   logic               load_sym;

   // Single read port: the shift passes read the neighbor of the pointer.
   always_comb begin
      rd_ptr = ptr_ff;
      if (cmd.step_ins) begin
         rd_ptr = ptr_ff - LEN_W'(1);
      end else if (cmd.step_del) begin
         rd_ptr = ptr_ff + LEN_W'(1);
      end
   end

   assign rd_data  = store_ff[rd_ptr[ADDR_W-1:0]];
   assign run_next = ((ptr_ff != '0) && (rd_data == prev_ff)) ? run_ff + LEN_W'(1)
                                                              : LEN_W'(1);

   assign len_c = CMP_W'(len_ff);
   assign idx_c = CMP_W'(req_index);

   // Resolve the target slot and legality of insert and delete positions.
   always_comb begin
      ins_slot   = '0;
      del_slot   = '0;
      ins_pos_ok = 1'b0;
      del_pos_ok = 1'b0;
      unique case (req_mode)
         MODE_FRONT: begin
            ins_pos_ok = 1'b1;
            del_pos_ok = 1'b1;
         end
         MODE_BACK: begin
            ins_slot   = ADDR_W'(len_ff);
            del_slot   = ADDR_W'(len_ff - LEN_W'(1));
            ins_pos_ok = 1'b1;
            del_pos_ok = 1'b1;
         end
         MODE_INDEX: begin
            ins_slot   = ADDR_W'(req_index - INDEX_W'(1));
            del_slot   = ADDR_W'(req_index - INDEX_W'(1));
            ins_pos_ok = (idx_c != '0) && (idx_c <= len_c + CMP_W'(1));
            del_pos_ok = (idx_c != '0) && (idx_c <= len_c);
         end
         default: ;
      endcase
   end

   assign sts.ins_ok    = ins_pos_ok && (len_ff != LEN_W'(CAPACITY));
   assign sts.del_ok    = del_pos_ok && (len_ff != '0);
   assign sts.ins_done  = (ptr_ff == LEN_W'(slot_ff));
   assign sts.del_done  = ((CMP_W'(ptr_ff) + CMP_W'(1)) >= len_c);
   assign sts.scan_done = (ptr_ff == len_ff);
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   assign load_sym = cmd.emit_step && (run_next == best_ff);

   // Storage has no reset; only entries below the length are ever read.
   always_ff @(posedge clock) begin
      if (cmd.step_ins || cmd.step_del) begin
         store_ff[ptr_ff[ADDR_W-1:0]] <= rd_data;
      end else if (cmd.put_ins) begin
         store_ff[slot_ff] <= sym_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_ins) begin
         ptr_ff  <= len_ff;
         slot_ff <= ins_slot;
         sym_ff  <= req_symbol;
      end else if (cmd.load_del) begin
         ptr_ff  <= LEN_W'(del_slot);
      end else if (cmd.load_rep) begin
         ptr_ff  <= '0;
         run_ff  <= '0;
         best_ff <= '0;
      end else if (cmd.step_ins) begin
         ptr_ff <= ptr_ff - LEN_W'(1);
      end else if (cmd.step_del) begin
         ptr_ff <= ptr_ff + LEN_W'(1);
      end else if (cmd.scan_step) begin
         ptr_ff  <= ptr_ff + LEN_W'(1);
         run_ff  <= run_next;
         prev_ff <= rd_data;
         if (run_next > best_ff) begin
            best_ff <= run_next;
         end
      end else if (cmd.scan_restart) begin
         ptr_ff <= '0;
         run_ff <= '0;
      end else if (cmd.emit_step) begin
         ptr_ff  <= ptr_ff + LEN_W'(1);
         run_ff  <= run_next;
         prev_ff <= rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (cmd.put_ins) begin
         len_ff <= len_ff + LEN_W'(1);
      end else if (cmd.fin_del) begin
         len_ff <= len_ff - LEN_W'(1);
      end
   end

   // Output register: loaded only when empty or being drained this cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_sym || cmd.emit_count) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_sym) begin
         out_count_ff <= 1'b0;
         out_sym_ff   <= rd_data;
         out_run_ff   <= '0;
      end else if (cmd.emit_count) begin
         out_count_ff <= 1'b1;
         out_sym_ff   <= '0;
         out_run_ff   <= RUN_W'(best_ff);
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_is_count = out_count_ff;
   assign rsp_symbol   = out_sym_ff;
   assign rsp_run      = out_run_ff;
   assign rsp_last     = out_count_ff;

endmodule

[src/positional_char_list_longest_run.sv]
// ----------------------------------------------------------------------------
// positional_char_list_longest_run
// Ordered list of byte symbols with positional insert and delete and a
// longest-run report, built as a controller and a datapath.
// ----------------------------------------------------------------------------
// Throughput is one command at a time; the length of the list sets how long
// a command runs, since the shift and scan passes move one entry per cycle
// through the single read port of the symbol storage, the emit pass only
// while the output register is free to take a result.
// Reset is synchronous and active high; it empties the list and the output
// register, while the symbol storage itself is not cleared.
module positional_char_list_longest_run (
   input  logic        clock,
   input  logic        reset,
   // Command channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] opcode, [3:2] position_mode, [9:4] position_index,
   // [17:10] symbol_in, [23:18] zero.
   input  logic [23:0] req_tdata,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] symbol_out, [13:8] longest_run, [15:14] zero.
   output logic [15:0] rsp_tdata,
   // [0] is_count.
   output logic        rsp_tuser,
   // Marks the final transaction of a report.
   output logic        rsp_tlast
);
   import pclr_pkg::*;

   pclr_cmd_type cmd;
   pclr_sts_type sts;
   sym_type      rsp_symbol;
   run_type      rsp_run;

   // The controller accepts a command transaction only when idle; the result
   // register in the datapath lets a new command start while the final result
   // of a report still waits downstream.
   pclr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tdata[1:0]),
      .sts        (sts),
      .cmd        (cmd)
   );

   pclr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_mode     (req_tdata[3:2]),
      .req_index    (req_tdata[9:4]),
      .req_symbol   (req_tdata[17:10]),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_is_count (rsp_tuser),
      .rsp_symbol   (rsp_symbol),
      .rsp_run      (rsp_run),
      .rsp_last     (rsp_tlast)
   );

   // Symbol results carry a zero length and the count result a zero symbol.
   assign rsp_tdata = {2'b00, rsp_run, rsp_symbol};

endmodule
